// ===== sv/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants of the paged cell allocator
// Holds the operation codes, the microprogram step addresses, the control
// word layout, the status bits that steer jumps and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

    // Width of the cell number on the ports.
    localparam int IDX_W = 10;
    // Width of the operation code.
    localparam int OP_W = 2;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    // Microprogram step addresses.
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE      = 5'd0;
    localparam step_t STEP_CLEAR     = 5'd1;
    localparam step_t STEP_DEC_ALLOC = 5'd2;
    localparam step_t STEP_DEC_FREE  = 5'd3;
    localparam step_t STEP_DEC_MARK  = 5'd4;
    localparam step_t STEP_RESP_NONE = 5'd5;
    localparam step_t STEP_A_PAGE    = 5'd6;
    localparam step_t STEP_A_END     = 5'd7;
    localparam step_t STEP_A_FETCH   = 5'd8;
    localparam step_t STEP_A_TEST    = 5'd9;
    localparam step_t STEP_A_FOUND   = 5'd10;
    localparam step_t STEP_A_NEXT    = 5'd11;
    localparam step_t STEP_F_CHECK   = 5'd12;
    localparam step_t STEP_F_UPD     = 5'd13;
    localparam step_t STEP_RESP_OK   = 5'd14;
    localparam step_t STEP_M_CHECK   = 5'd15;
    localparam step_t STEP_M_WR      = 5'd16;

    // Datapath actions, one per control word.
    typedef enum logic [3:0] {
        ACT_NOP        = 4'd0,
        ACT_CLEAR      = 4'd1,
        ACT_FETCH      = 4'd2,
        ACT_NEXT_PAGE  = 4'd3,
        ACT_FREE_UPD   = 4'd4,
        ACT_MARK_WR    = 4'd5,
        ACT_RESP_NONE  = 4'd6,
        ACT_RESP_FOUND = 4'd7,
        ACT_RESP_OK    = 4'd8
    } action_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER      = 4'd0,
        COND_ALWAYS     = 4'd1,
        COND_OP_ALLOC   = 4'd2,
        COND_OP_FREE    = 4'd3,
        COND_OP_MARK    = 4'd4,
        COND_EXHAUSTED  = 4'd5,
        COND_AT_END     = 4'd6,
        COND_CELL_BUSY  = 4'd7,
        COND_BAD_INDEX  = 4'd8,
        COND_CLEAR_MORE = 4'd9
    } cond_t;

    // One control word: action, jump condition and target, and an end mark
    // that returns the sequencer to idle when the jump is not taken.
    typedef struct packed {
        action_t action;
        cond_t   cond;
        step_t   target;
        logic    last;
    } ctl_word_t;

    // Status bits from the datapath that the jump conditions test.
    typedef struct packed {
        logic op_alloc;
        logic op_free;
        logic op_mark;
        logic exhausted;
        logic at_end;
        logic cell_busy;
        logic bad_index;
        logic clear_more;
    } status_t;

    // Microcode ROM.
    function automatic ctl_word_t microcode(input step_t s);
        ctl_word_t w;
        w = '{action: ACT_NOP, cond: COND_NEVER, target: STEP_IDLE, last: 1'b0};
        unique case (s)
            STEP_IDLE:      w = '{ACT_NOP,        COND_NEVER,      STEP_IDLE,      1'b0};
            STEP_CLEAR:     w = '{ACT_CLEAR,      COND_CLEAR_MORE, STEP_CLEAR,     1'b1};
            STEP_DEC_ALLOC: w = '{ACT_NOP,        COND_OP_ALLOC,   STEP_A_PAGE,    1'b0};
            STEP_DEC_FREE:  w = '{ACT_NOP,        COND_OP_FREE,    STEP_F_CHECK,   1'b0};
            STEP_DEC_MARK:  w = '{ACT_NOP,        COND_OP_MARK,    STEP_M_CHECK,   1'b0};
            STEP_RESP_NONE: w = '{ACT_RESP_NONE,  COND_NEVER,      STEP_IDLE,      1'b1};
            STEP_A_PAGE:    w = '{ACT_NOP,        COND_EXHAUSTED,  STEP_RESP_NONE, 1'b0};
            STEP_A_END:     w = '{ACT_NOP,        COND_AT_END,     STEP_A_NEXT,    1'b0};
            STEP_A_FETCH:   w = '{ACT_FETCH,      COND_NEVER,      STEP_IDLE,      1'b0};
            STEP_A_TEST:    w = '{ACT_NOP,        COND_CELL_BUSY,  STEP_A_END,     1'b0};
            STEP_A_FOUND:   w = '{ACT_RESP_FOUND, COND_NEVER,      STEP_IDLE,      1'b1};
            STEP_A_NEXT:    w = '{ACT_NEXT_PAGE,  COND_ALWAYS,     STEP_A_PAGE,    1'b0};
            STEP_F_CHECK:   w = '{ACT_NOP,        COND_BAD_INDEX,  STEP_RESP_NONE, 1'b0};
            STEP_F_UPD:     w = '{ACT_FREE_UPD,   COND_NEVER,      STEP_IDLE,      1'b0};
            STEP_RESP_OK:   w = '{ACT_RESP_OK,    COND_NEVER,      STEP_IDLE,      1'b1};
            STEP_M_CHECK:   w = '{ACT_NOP,        COND_BAD_INDEX,  STEP_RESP_NONE, 1'b0};
            STEP_M_WR:      w = '{ACT_MARK_WR,    COND_ALWAYS,     STEP_RESP_OK,   1'b0};
            default:        w = '{ACT_NOP,        COND_ALWAYS,     STEP_IDLE,      1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/paged_cell_allocator.sv =====
// ----------------------------------------------------------------------------
// paged_cell_allocator: next-fit cell allocator over pages of doubling size
// A microcoded sequencer drives a datapath of busy bits and page scan hints.
// ----------------------------------------------------------------------------
// Usage:
//   A word (op, cell_index, busy_req) is taken at a rising edge with start
//   high and busy low. Exactly one result word follows: done is high for one
//   cycle with found and result_cell; the receiver cannot stall it.
// Timing: the sequencer runs one microprogram control word per cycle and
//   done follows the responding step. An alloc examines each cell in
//   A_END, A_FETCH and A_TEST and moves past a page in A_END, A_NEXT and
//   A_PAGE; with nothing left it goes from A_PAGE to the no-result answer.
//   A free or a mark aimed past the last cell answers from its check step,
//   and the unused code falls through the decode steps to the no-result
//   answer. A_TEST waits on the busy memory, which has a registered read port.
// Throughput: one word at a time; the next may be taken in the cycle in
//   which done is high.
// Reset: the hints and current page return to their start values and the
//   busy memory is cleared by a pass of one cell a cycle over all TOTAL_CELLS
//   cells (1008 at the default sizes), during which busy stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_cell_allocator
    import pca_pkg::*;
#(
    parameter int NUM_PAGES        = 6,
    parameter int FIRST_PAGE_CELLS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic             busy_req,
    output logic                  done,
    output logic                  found,
    output logic [IDX_W-1:0]      result_cell
);

    logic      accept;
    ctl_word_t ctl;
    status_t   status;

    // A word is taken when the sequencer idles.
    assign accept = start && !busy;

    // Microprogram sequencer.
    pca_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    // Datapath.
    pca_datapath #(
        .NUM_PAGES        (NUM_PAGES),
        .FIRST_PAGE_CELLS (FIRST_PAGE_CELLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .cell_index  (cell_index),
        .busy_req    (busy_req),
        .ctl         (ctl),
        .status      (status),
        .done        (done),
        .found       (found),
        .result_cell (result_cell)
    );

    // An accepted word always starts the microprogram.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not start the sequencer");

    // Every program run for a word ends with a result strobe.
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) && !$past(ctl.action == ACT_CLEAR) |-> done)
        else $error("sequencer went idle without a result");

    // Results never come in adjacent cycles.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// ===== sv/pca_sequencer.sv =====
// ----------------------------------------------------------------------------
// pca_sequencer: microprogram sequencer of the paged cell allocator
// Holds the step counter, reads the control word from the microcode ROM and
// picks the next step from the jump condition and the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_sequencer
    import pca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire status_t   status,
    output ctl_word_t      ctl,
    output logic           busy
);

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // Control word of the current step.
    assign ctl  = microcode(step_reg);
    assign busy = (step_reg != STEP_IDLE);

    // Evaluate the jump condition.
    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_OP_ALLOC:   cond_true = status.op_alloc;
            COND_OP_FREE:    cond_true = status.op_free;
            COND_OP_MARK:    cond_true = status.op_mark;
            COND_EXHAUSTED:  cond_true = status.exhausted;
            COND_AT_END:     cond_true = status.at_end;
            COND_CELL_BUSY:  cond_true = status.cell_busy;
            COND_BAD_INDEX:  cond_true = status.bad_index;
            COND_CLEAR_MORE: cond_true = status.clear_more;
            default:         cond_true = 1'b0;
        endcase
    end

    // Next step: wait in idle for a word, else jump, finish or fall through.
    always_comb
    begin
        if (step_reg == STEP_IDLE)
        begin
            step_next = accept ? STEP_DEC_ALLOC : STEP_IDLE;
        end
        else if (cond_true)
        begin
            step_next = ctl.target;
        end
        else if (ctl.last)
        begin
            step_next = STEP_IDLE;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    // Step counter; reset starts the clearing pass of the busy store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pca_datapath.sv =====
// ----------------------------------------------------------------------------
// pca_datapath: storage and arithmetic of the paged cell allocator
// Holds the busy-bit memory, the per-page scan hints, the current page and the
// result registers, all driven by the control word, and the input word latch.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_datapath
    import pca_pkg::*;
#(
    parameter int NUM_PAGES        = 6,
    parameter int FIRST_PAGE_CELLS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic             busy_req,
    input  wire ctl_word_t        ctl,
    output status_t               status,
    output logic                  done,
    output logic                  found,
    output logic [IDX_W-1:0]      result_cell
);

    localparam int TOTAL_CELLS = FIRST_PAGE_CELLS * ((1 << NUM_PAGES) - 1);
    localparam int TW = $clog2(TOTAL_CELLS + 1);
    // Cell width: holds the cell count and every port cell number.
    localparam int CW = (TW > IDX_W) ? TW : IDX_W;
    localparam int AW = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int PIW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    // First global cell of page p.
    function automatic int page_first(input int p);
        return FIRST_PAGE_CELLS * ((1 << p) - 1);
    endfunction

    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] index_reg;
    logic             busy_req_reg;

    logic [CW-1:0]    hint_reg [NUM_PAGES];
    logic [PW-1:0]    cur_page_reg;
    logic [CW-1:0]    scan_cell_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             rd_bit_reg;
    logic             busy_mem [TOTAL_CELLS];

    logic             done_reg;
    logic             found_reg;
    logic [IDX_W-1:0] result_reg;

    logic [CW-1:0]    page_end_tab [NUM_PAGES];
    logic [CW-1:0]    index_ext;
    logic [PIW-1:0]   free_page;
    logic [PIW-1:0]   hint_sel;
    logic [CW-1:0]    hint_rd;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             mem_wdata;

    // Constant table of page ends.
    always_comb
    begin
        for (int q = 0; q < NUM_PAGES; q++)
        begin
            page_end_tab[q] = CW'(page_first(q + 1));
        end
    end

    assign index_ext = CW'(index_reg);

    // Page of the requested cell: count the page ends at or below it.
    always_comb
    begin
        free_page = '0;
        for (int q = 0; q < NUM_PAGES - 1; q++)
        begin
            if (index_ext >= page_end_tab[q])
            begin
                free_page = PIW'(q + 1);
            end
        end
    end

    // One hint read port, shared by the scan and the free update.
    assign hint_sel = (op_reg == OP_FREE) ? free_page : cur_page_reg[PIW-1:0];
    assign hint_rd  = hint_reg[hint_sel];

    // Status for the sequencer.
    assign status.op_alloc   = (op_reg == OP_ALLOC);
    assign status.op_free    = (op_reg == OP_FREE);
    assign status.op_mark    = (op_reg == OP_MARK);
    assign status.exhausted  = (cur_page_reg == PW'(NUM_PAGES));
    assign status.at_end     = (hint_rd >= page_end_tab[hint_sel]);
    assign status.cell_busy  = rd_bit_reg;
    assign status.bad_index  = (index_ext >= CW'(TOTAL_CELLS));
    assign status.clear_more = (clr_cnt_reg != AW'(TOTAL_CELLS - 1));

    // Input word latch.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            index_reg    <= cell_index;
            busy_req_reg <= busy_req;
        end
    end

    // Busy memory write port: the clearing pass or a mark.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 1'b0;
        case (ctl.action)
            ACT_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ACT_MARK_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = index_ext[AW-1:0];
                mem_wdata = busy_req_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Busy memory with registered read at the scan hint.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            busy_mem[mem_waddr] <= mem_wdata;
        end
        rd_bit_reg <= busy_mem[hint_rd[AW-1:0]];
    end

    // Scan cell under test.
    always_ff @(posedge clk)
    begin
        if (ctl.action == ACT_FETCH)
        begin
            scan_cell_reg <= hint_rd;
        end
    end

    // Hints, current page and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PAGES; p++)
            begin
                hint_reg[p] <= CW'(page_first(p));
            end
            cur_page_reg <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            case (ctl.action)
                ACT_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                ACT_FETCH:
                begin
                    hint_reg[hint_sel] <= hint_rd + CW'(1);
                end
                ACT_NEXT_PAGE:
                begin
                    cur_page_reg <= cur_page_reg + PW'(1);
                end
                ACT_FREE_UPD:
                begin
                    if (index_ext < hint_rd)
                    begin
                        hint_reg[hint_sel] <= index_ext;
                    end
                    if (PW'(free_page) < cur_page_reg)
                    begin
                        cur_page_reg <= PW'(free_page);
                    end
                end
                default:
                begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.action == ACT_RESP_NONE) ||
                        (ctl.action == ACT_RESP_FOUND) ||
                        (ctl.action == ACT_RESP_OK);
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        case (ctl.action)
            ACT_RESP_NONE:
            begin
                found_reg  <= 1'b0;
                result_reg <= '0;
            end
            ACT_RESP_FOUND:
            begin
                found_reg  <= 1'b1;
                result_reg <= scan_cell_reg[IDX_W-1:0];
            end
            ACT_RESP_OK:
            begin
                found_reg  <= 1'b1;
                result_reg <= '0;
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign result_cell = result_reg;

endmodule

`default_nettype wire
